/* sv/signed_fixed_point_decimal_formatter_core_assert.svh */
// Assertion macros for the decimal formatter core.
// Included by RTL files that carry concurrent checks; uses clk and rst of the includer.
`ifndef SIGNED_FIXED_POINT_DECIMAL_FORMATTER_CORE_ASSERT_SVH
`define SIGNED_FIXED_POINT_DECIMAL_FORMATTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdf: implication check failed");
`define SFDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdf: next-cycle check failed");
`else
`define SFDF_ASSERT_IMP(lbl, ante, cons)
`define SFDF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/sfdf_pkg.sv */
// Shared constants, types and the double-dabble stage function for the formatter.
// No dependencies.
package sfdf_pkg;

  localparam int DIGIT_COUNT     = 10;
  localparam int BCD_W           = 40;
  localparam int BIN_W           = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DAB_STAGES      = BIN_W / STEPS_PER_STAGE;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POINT = 8'h2E;

  localparam logic [1:0] CFG_FIRST_DIGIT     = 2'd0;
  localparam logic [1:0] CFG_POINT_POSITION  = 2'd1;
  localparam logic [1:0] CFG_FRACTION_DIGITS = 2'd2;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } pipe_t;

  // four shift-add-3 steps
  function automatic pipe_t dabble_stage(input pipe_t s);
    pipe_t r;
    r = s;
    for (int st = 0; st < STEPS_PER_STAGE; st++) begin
      for (int k = 0; k < BCD_W / 4; k++) begin
        if (r.bcd[k*4 +: 4] >= 4'd5) r.bcd[k*4 +: 4] = r.bcd[k*4 +: 4] + 4'd3;
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[BIN_W-1]};
      r.bin = {r.bin[BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* sv/signed_fixed_point_decimal_formatter_core.sv */
// Conversion: input stage plus 8 double-dabble stages of 4 steps; new value may enter each
// cycle unless in_stall is high. Emission: one character per cycle unless out_stall holds it,
// 2 to 12 characters per value, set by the character sequencer.
// The sequencer takes the next converted value only once it has returned to idle.
// Reset (rst, synchronous, active high) clears pipeline valids, sequencer, output valid,
// and loads first_digit=1, point_position=11, fraction_digits=0.
`include "signed_fixed_point_decimal_formatter_core_assert.svh"

module signed_fixed_point_decimal_formatter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_code,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import sfdf_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_SIGN, E_INT, E_POINT, E_FRAC} emit_state_t;

  localparam logic [4:0] DC5 = 5'(DIGIT_COUNT);

  logic [3:0] first_digit;
  logic [3:0] point_position;
  logic [3:0] fraction_digits;

  pipe_t               stg [DAB_STAGES+1];
  logic [DAB_STAGES:0] vld;
  logic [DAB_STAGES+1:0] rdy;

  emit_state_t state;
  logic [3:0]  ds [DIGIT_COUNT];
  logic [3:0]  emit_position;
  logic        nonzero_seen;
  logic        negative_flag;

  logic [31:0] raw;
  logic [31:0] mag;
  logic        load;
  logic        emit;
  logic [3:0]  start_eff;
  logic [3:0]  point_eff;
  logic [4:0]  stop;
  logic [4:0]  p_inc;
  logic [3:0]  pm1;
  logic [3:0]  d_cur;
  logic        int_first_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_digit     <= 4'd1;
      point_position  <= 4'd11;
      fraction_digits <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_DIGIT:     first_digit     <= cfg_data;
        CFG_POINT_POSITION:  point_position  <= cfg_data;
        CFG_FRACTION_DIGITS: fraction_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- conversion pipeline ----
  assign raw = value;
  always_comb begin
    if (!raw[31])                 mag = raw;
    else if (raw[30:0] == 31'd0)  mag = 32'h7FFF_FFFF;
    else                          mag = ~raw + 32'd1;
  end

  assign load = (state == E_IDLE);
  always_comb begin
    rdy[DAB_STAGES+1] = load;
    for (int i = DAB_STAGES; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i <= DAB_STAGES; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      stg[0].neg <= raw[31];
      stg[0].bcd <= '0;
      stg[0].bin <= mag;
    end
    for (int i = 1; i <= DAB_STAGES; i++) begin
      if (rdy[i]) stg[i] <= dabble_stage(stg[i-1]);
    end
  end

  // ---- character sequencer ----
  assign start_eff    = (first_digit == 4'd0) ? 4'd1 : first_digit;
  assign point_eff    = (point_position == 4'd0) ? 4'd1 : point_position;
  assign stop         = {1'b0, point_eff} + {1'b0, fraction_digits};
  assign p_inc        = {1'b0, emit_position} + 5'd1;
  assign int_first_ok = (start_eff < point_eff) && ({1'b0, start_eff} <= DC5);
  assign pm1          = emit_position - 4'd1;
  assign d_cur        = ({1'b0, pm1} < DC5) ? ds[pm1] : 4'd0;
  assign emit         = (state != E_IDLE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= E_IDLE;
      out_valid     <= 1'b0;
      emit_position <= 4'd0;
      nonzero_seen  <= 1'b0;
      negative_flag <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        unique case (state)
          E_SIGN: begin
            char_code     <= negative_flag ? CH_MINUS : CH_SPACE;
            last          <= 1'b0;
            nonzero_seen  <= 1'b0;
            emit_position <= int_first_ok ? start_eff : 4'd0;
            state         <= int_first_ok ? E_INT : E_POINT;
          end
          E_INT: begin
            last <= 1'b0;
            if (nonzero_seen || d_cur != 4'd0) begin
              nonzero_seen <= 1'b1;
              char_code    <= CH_ZERO + {4'd0, d_cur};
            end else begin
              char_code    <= CH_SPACE;
            end
            if (p_inc < {1'b0, point_eff} && p_inc <= DC5) begin
              emit_position <= p_inc[3:0];
            end else begin
              state <= E_POINT;
            end
          end
          E_POINT: begin
            char_code <= CH_POINT;
            if (fraction_digits != 4'd0 && {1'b0, point_eff} <= DC5) begin
              last          <= 1'b0;
              emit_position <= point_eff;
              state         <= E_FRAC;
            end else begin
              last  <= 1'b1;
              state <= E_IDLE;
            end
          end
          E_FRAC: begin
            char_code <= CH_ZERO + {4'd0, d_cur};
            if (p_inc < stop && p_inc <= DC5) begin
              last          <= 1'b0;
              emit_position <= p_inc[3:0];
            end else begin
              last  <= 1'b1;
              state <= E_IDLE;
            end
          end
          default: ;
        endcase
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && vld[DAB_STAGES]) begin
        state         <= E_SIGN;
        negative_flag <= stg[DAB_STAGES].neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld[DAB_STAGES]) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        ds[i] <= stg[DAB_STAGES].bcd[(DIGIT_COUNT-1-i)*4 +: 4];
      end
    end
  end

  `SFDF_ASSERT_IMP(a_frac_pos, state == E_FRAC, emit_position >= 4'd1 && {1'b0, emit_position} <= DC5)
  `SFDF_ASSERT_IMP(a_int_pos, state == E_INT, emit_position >= start_eff && emit_position < point_eff)
  `SFDF_ASSERT_NXT(a_tail_hold, vld[DAB_STAGES] && !load, vld[DAB_STAGES])
  `SFDF_ASSERT_NXT(a_load_sign, load && vld[DAB_STAGES], state == E_SIGN)

endmodule
